// ----- rtl/fdnh8_pkg.sv -----
package fdnh8_pkg;

  // Default sizes of the stores and the length scale.
  localparam int unsigned PREDELAY_DEPTH_DEF      = 8192;
  localparam int unsigned LENGTH_SCALE_DEF        = 1;
  localparam int unsigned ELEMENT_STORE_DEPTH_DEF = 74381;

  localparam int unsigned NUM_ELEM  = 16;
  localparam int unsigned NUM_PAIRS = 8;

  // Fixed Q3.21 constants.
  localparam logic signed [32:0] K_SQRT_EIGHTH  = 33'sd741455;
  localparam logic signed [32:0] K_SMOOTH       = 33'sd1258291;
  localparam logic signed [32:0] K_FIVE_FOURTHS = 33'sd2621440;
  localparam logic signed [32:0] K_TWENTIETH    = 33'sd104858;
  localparam logic signed [23:0] K_FB_MAIN      = 24'sd1258291;
  localparam logic signed [23:0] K_FB_TAIL      = 24'sd209715;

  // Command codes of an input word.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_COEF   = 1'b1;

  // Coefficient kinds.
  localparam logic [2:0] KIND_GMF = 3'd0;
  localparam logic [2:0] KIND_GLO = 3'd1;
  localparam logic [2:0] KIND_WLO = 3'd2;
  localparam logic [2:0] KIND_WHI = 3'd3;
  localparam logic [2:0] KIND_FB  = 3'd4;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_PREDELAY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 1'd1;

  localparam logic [13:0] PREDELAY_RESET = 14'd2400;
  localparam logic [15:0] GAIN_RESET     = 16'd8192;

  // Unscaled length of each delay element.
  function automatic int unsigned elem_len(int unsigned i);
    int unsigned r;
    case (i)
      0:  r = 839;
      1:  r = 5893;
      2:  r = 1181;
      3:  r = 6158;
      4:  r = 1229;
      5:  r = 6780;
      6:  r = 2477;
      7:  r = 6254;
      8:  r = 2731;
      9:  r = 6790;
      10: r = 1361;
      11: r = 9020;
      12: r = 3203;
      13: r = 8118;
      14: r = 1949;
      default: r = 10398;
    endcase
    return r;
  endfunction

  // Start address of an element in the packed store.
  function automatic int unsigned elem_base(int unsigned i, int unsigned scale);
    int unsigned acc;
    acc = 0;
    for (int unsigned j = 0; j < NUM_ELEM; j++) begin
      if (j < i) acc = acc + elem_len(j) * scale;
    end
    return acc;
  endfunction

  // Feedback coefficient held after reset.
  function automatic logic signed [23:0] fb_default(int unsigned i);
    logic signed [23:0] r;
    if (i % 2 == 1) r = K_FB_TAIL;
    else if (i == 0 || i == 6 || i == 10 || i == 12) r = -K_FB_MAIN;
    else r = K_FB_MAIN;
    return r;
  endfunction

  // Saturate a 33-bit value to 32 bits.
  function automatic logic signed [31:0] sat33(logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] add_s(logic signed [31:0] a, logic signed [31:0] b);
    return sat33(33'(a) + 33'(b));
  endfunction

  function automatic logic signed [31:0] sub_s(logic signed [31:0] a, logic signed [31:0] b);
    return sat33(33'(a) - 33'(b));
  endfunction

  // Round half up at bit 21 of a product and saturate to 32 bits.
  function automatic logic signed [31:0] round21(logic signed [64:0] p);
    logic signed [65:0] s;
    logic signed [44:0] q;
    logic signed [31:0] r;
    s = 66'(p) + 66'sd1048576;
    q = 45'(s >>> 21);
    if (q > 45'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (q < -45'sd2147483648) r = 32'sh8000_0000;
    else r = q[31:0];
    return r;
  endfunction

  // Round half up at bit 28 of a product and saturate to 32 bits.
  function automatic logic signed [31:0] round28(logic signed [64:0] p);
    logic signed [65:0] s;
    logic signed [37:0] q;
    logic signed [31:0] r;
    s = 66'(p) + 66'sd134217728;
    q = 38'(s >>> 28);
    if (q > 38'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (q < -38'sd2147483648) r = 32'sh8000_0000;
    else r = q[31:0];
    return r;
  endfunction

  // Clamp a value to 24 bits.
  function automatic logic signed [23:0] clamp24(logic signed [31:0] v);
    logic signed [23:0] r;
    if (v > 32'sd8388607) r = 24'sh7FFFFF;
    else if (v < -32'sd8388608) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

endpackage

// ----- rtl/fdnh8_ram.sv -----
module fdnh8_ram
  import fdnh8_pkg::*;
#(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single port: a write or a registered read each cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/fdn_reverb_hadamard8.sv -----
// Eight-line feedback delay network reverb, one sample in, W/X/Y/Z contributions out.
// A sample word (command 0) gives one result word; a coefficient word (command 1)
// loads one damping or feedback coefficient and gives no result. The state lives in
// two single-port RAMs (the packed delay elements and the predelay line) and all
// arithmetic runs through one shared 32 x 33 multiplier, so a sample word is worked
// in steps: smoothing and predelay, each of the eight first-stage elements, the
// butterfly, the outputs and each of the eight second-stage elements. After reset both
// RAMs are cleared, one address a cycle, up to the depth of the larger one, during which
// no input word is taken; configuration writes are taken at any time.
module fdn_reverb_hadamard8
  import fdnh8_pkg::*;
#(
  parameter int unsigned PREDELAY_DEPTH      = PREDELAY_DEPTH_DEF,
  parameter int unsigned LENGTH_SCALE        = LENGTH_SCALE_DEF,
  parameter int unsigned ELEMENT_STORE_DEPTH = ELEMENT_STORE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [15:0]           cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  command_i,
  input  logic signed [23:0]    sample_i,
  input  logic [15:0]           gain_i,
  input  logic [3:0]            coef_element_i,
  input  logic [2:0]            coef_kind_i,
  input  logic signed [23:0]    coef_value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [31:0]    w_out_o,
  output logic signed [31:0]    x_out_o,
  output logic signed [31:0]    y_out_o,
  output logic signed [31:0]    z_out_o
);

  localparam int unsigned EAW   = $clog2(ELEMENT_STORE_DEPTH);
  localparam int unsigned PAW   = $clog2(PREDELAY_DEPTH);
  localparam int unsigned TOTAL = elem_base(NUM_ELEM, LENGTH_SCALE);
  localparam int unsigned EXT_W =
      $clog2((TOTAL > ELEMENT_STORE_DEPTH ? TOTAL : ELEMENT_STORE_DEPTH) + 1) + 1;
  localparam int unsigned POS_W = $clog2(elem_len(NUM_ELEM - 1) * LENGTH_SCALE + 1);
  localparam int unsigned CLR_N =
      ELEMENT_STORE_DEPTH > PREDELAY_DEPTH ? ELEMENT_STORE_DEPTH : PREDELAY_DEPTH;
  localparam int unsigned CLR_W = $clog2(CLR_N + 1);
  localparam int unsigned DW    = (PAW + 1 > 14 ? PAW + 1 : 14) + 1;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_P0, S_P1, S_P2, S_PM, S_PA,
    S_RD, S_D, S_T, S_L1, S_L2, S_L3, S_L4, S_H1, S_H2, S_V1, S_V2, S_W, S_R,
    S_B, S_O1, S_O2, S_O3, S_O4, S_O5, S_O6, S_O7, S_OUT
  } state_e;

  state_e st_q;
  logic [CLR_W-1:0] clr_q;
  logic [2:0]       k_q;
  logic             stage2_q;
  logic [1:0]       b_q;

  logic [13:0] cfg_pre_q;
  logic [15:0] cfg_gain_q;

  logic signed [23:0] gmf_q [NUM_ELEM];
  logic signed [23:0] glo_q [NUM_ELEM];
  logic signed [23:0] wlo_q [NUM_ELEM];
  logic signed [23:0] whi_q [NUM_ELEM];
  logic signed [23:0] fb_q  [NUM_ELEM];
  logic signed [31:0] lo_q  [NUM_ELEM];
  logic signed [31:0] hi_q  [NUM_ELEM];
  logic [POS_W-1:0]   pos_q [NUM_ELEM];
  logic signed [31:0] mix_q [NUM_PAIRS];

  logic [PAW-1:0]     wr_q;
  logic signed [23:0] s_q;
  logic [31:0]        g_q;
  logic signed [31:0] sm_q, x_q, in_q, t_q, v_q, w_q, xo_q;
  logic signed [31:0] rw_q, rx_q, ry_q, rz_q;
  logic signed [64:0] prod_q;

  logic               out_valid_q;
  logic signed [31:0] w_out_q, x_out_q, y_out_q, z_out_q;

  // Element base addresses, fixed at elaboration.
  logic [EXT_W-1:0] base_w [NUM_ELEM];
  logic [POS_W-1:0] len_w  [NUM_ELEM];
  for (genvar j = 0; j < NUM_ELEM; j++) begin : g_base
    assign base_w[j] = EXT_W'(elem_base(j, LENGTH_SCALE));
    assign len_w[j]  = POS_W'(elem_len(j) * LENGTH_SCALE);
  end

  logic [3:0] e_w;
  assign e_w = {k_q, stage2_q};

  // Element store address and range check.
  logic [EXT_W-1:0] ea_full;
  logic             ea_ok;
  assign ea_full = base_w[e_w] + EXT_W'(pos_q[e_w]);
  assign ea_ok   = ea_full < EXT_W'(ELEMENT_STORE_DEPTH);

  // Predelay read address.
  logic [DW-1:0]  del_w, wr_ext;
  logic [PAW-1:0] rd_w;
  assign del_w  = (DW'(cfg_pre_q) > DW'(PREDELAY_DEPTH)) ? DW'(PREDELAY_DEPTH)
                                                         : DW'(cfg_pre_q);
  assign wr_ext = DW'(wr_q);
  assign rd_w   = (wr_ext >= del_w) ? PAW'(wr_ext - del_w)
                                    : PAW'(wr_ext + DW'(PREDELAY_DEPTH) - del_w);

  // Rounded products.
  logic signed [31:0] qm21, qm28;
  assign qm21 = round21(prod_q);
  assign qm28 = round28(prod_q);

  // Element store.
  logic               e_we;
  logic [EAW-1:0]     e_addr;
  logic [23:0]        e_wdata, e_rdata;
  logic signed [33:0] v_rnd;
  logic signed [31:0] v_shr;

  assign v_rnd = 34'(v_q) + 34'sd4;
  assign v_shr = 32'(v_rnd >>> 3);

  always_comb begin
    if (st_q == S_CLR) begin
      e_we    = clr_q < CLR_W'(ELEMENT_STORE_DEPTH);
      e_addr  = clr_q[EAW-1:0];
      e_wdata = '0;
    end else begin
      e_we    = (st_q == S_W) && ea_ok;
      e_addr  = ea_full[EAW-1:0];
      e_wdata = clamp24(v_shr);
    end
  end

  fdnh8_ram #(.WIDTH(24), .DEPTH(ELEMENT_STORE_DEPTH)) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .addr_i  (e_addr),
    .wdata_i (e_wdata),
    .rdata_o (e_rdata)
  );

  // Predelay store.
  logic           p_we;
  logic [PAW-1:0] p_addr;
  logic [23:0]    p_wdata, p_rdata;

  always_comb begin
    if (st_q == S_CLR) begin
      p_we    = clr_q < CLR_W'(PREDELAY_DEPTH);
      p_addr  = clr_q[PAW-1:0];
      p_wdata = '0;
    end else begin
      p_we    = st_q == S_P2;
      p_addr  = (st_q == S_P0) ? rd_w : wr_q;
      p_wdata = clamp24(sm_q);
    end
  end

  fdnh8_ram #(.WIDTH(24), .DEPTH(PREDELAY_DEPTH)) u_pre_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .addr_i  (p_addr),
    .wdata_i (p_wdata),
    .rdata_o (p_rdata)
  );

  // Operand selection for the shared multiplier.
  logic signed [31:0] ma;
  logic signed [32:0] mc;
  logic signed [31:0] d_w;
  assign d_w = ea_ok ? (32'(signed'(e_rdata)) <<< 3) : 32'sd0;

  always_comb begin
    ma = 32'sd0;
    mc = 33'sd0;
    case (st_q)
      S_P0: begin ma = sub_s(32'(s_q), sm_q);      mc = K_SMOOTH; end
      S_PM: begin ma = mix_q[k_q];                 mc = K_SQRT_EIGHTH; end
      S_D:  begin ma = d_w;                        mc = 33'(gmf_q[e_w]); end
      S_L1: begin ma = sub_s(t_q, lo_q[e_w]);      mc = 33'(wlo_q[e_w]); end
      S_L3: begin ma = lo_q[e_w];                  mc = 33'(glo_q[e_w]); end
      S_H1: begin ma = sub_s(t_q, hi_q[e_w]);      mc = 33'(whi_q[e_w]); end
      S_V1: begin ma = hi_q[e_w];                  mc = 33'(fb_q[e_w]); end
      S_W:  begin ma = v_q;                        mc = 33'(fb_q[e_w]); end
      S_O1: begin ma = mix_q[0];                   mc = K_FIVE_FOURTHS; end
      S_O2: begin ma = mix_q[2];                   mc = K_TWENTIETH; end
      S_O3: begin ma = w_q;                        mc = signed'({1'b0, g_q}); end
      S_O4: begin ma = xo_q;                       mc = signed'({1'b0, g_q}); end
      S_O5: begin ma = mix_q[2];                   mc = signed'({1'b0, g_q}); end
      S_O6: begin ma = mix_q[4];                   mc = signed'({1'b0, g_q}); end
      default: begin ma = 32'sd0;                  mc = 33'sd0; end
    endcase
  end

  logic in_acc;
  assign in_acc = in_valid_i && (st_q == S_IDLE);

  // Sequencer and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_CLR;
      clr_q       <= '0;
      k_q         <= '0;
      stage2_q    <= 1'b0;
      b_q         <= '0;
      cfg_pre_q   <= PREDELAY_RESET;
      cfg_gain_q  <= GAIN_RESET;
      wr_q        <= '0;
      sm_q        <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_ELEM; i++) begin
        gmf_q[i] <= '0;
        glo_q[i] <= '0;
        wlo_q[i] <= '0;
        whi_q[i] <= '0;
        fb_q[i]  <= fb_default(i);
        lo_q[i]  <= '0;
        hi_q[i]  <= '0;
        pos_q[i] <= '0;
      end
      for (int i = 0; i < NUM_PAIRS; i++) begin
        mix_q[i] <= '0;
      end
    end else begin
      prod_q <= ma * mc;

      // Configuration writes.
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_PREDELAY: cfg_pre_q  <= cfg_data_i[13:0];
          CFG_GAIN:     cfg_gain_q <= cfg_data_i;
          default: ;
        endcase
      end

      // The result word leaves once taken, unless a new one replaces it this cycle.
      if (out_valid_q && out_ready_i && (st_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end

      unique case (st_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == CLR_W'(CLR_N - 1)) st_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            if (command_i == CMD_COEF) begin
              case (coef_kind_i)
                KIND_GMF: gmf_q[coef_element_i] <= coef_value_i;
                KIND_GLO: glo_q[coef_element_i] <= coef_value_i;
                KIND_WLO: wlo_q[coef_element_i] <= coef_value_i;
                KIND_WHI: whi_q[coef_element_i] <= coef_value_i;
                KIND_FB:  fb_q[coef_element_i]  <= coef_value_i;
                default: ;
              endcase
            end else begin
              s_q  <= sample_i;
              g_q  <= gain_i * cfg_gain_q;
              st_q <= S_P0;
            end
          end
        end
        S_P0: st_q <= S_P1;
        S_P1: begin
          x_q  <= 32'(signed'(p_rdata));
          sm_q <= add_s(sm_q, qm21);
          st_q <= S_P2;
        end
        S_P2: begin
          wr_q     <= (wr_q == PAW'(PREDELAY_DEPTH - 1)) ? '0 : wr_q + 1'b1;
          k_q      <= '0;
          stage2_q <= 1'b0;
          st_q     <= S_PM;
        end
        S_PM: st_q <= S_PA;
        S_PA: begin
          in_q <= add_s(qm21, x_q);
          st_q <= S_RD;
        end
        S_RD: begin
          if (stage2_q) in_q <= mix_q[k_q];
          st_q <= S_D;
        end
        S_D:  st_q <= S_T;
        S_T: begin
          t_q  <= qm21;
          st_q <= S_L1;
        end
        S_L1: st_q <= S_L2;
        S_L2: begin
          lo_q[e_w] <= add_s(lo_q[e_w], qm21);
          st_q      <= S_L3;
        end
        S_L3: st_q <= S_L4;
        S_L4: begin
          t_q  <= add_s(t_q, qm21);
          st_q <= S_H1;
        end
        S_H1: st_q <= S_H2;
        S_H2: begin
          hi_q[e_w] <= add_s(hi_q[e_w], qm21);
          st_q      <= S_V1;
        end
        S_V1: st_q <= S_V2;
        S_V2: begin
          v_q  <= sub_s(in_q, qm21);
          st_q <= S_W;
        end
        S_W:  st_q <= S_R;
        S_R: begin
          mix_q[k_q] <= add_s(hi_q[e_w], qm21);
          pos_q[e_w] <= (pos_q[e_w] == len_w[e_w] - 1'b1) ? '0 : pos_q[e_w] + 1'b1;
          if (k_q == 3'd7) begin
            k_q  <= '0;
            b_q  <= '0;
            st_q <= stage2_q ? S_IDLE : S_B;
          end else begin
            k_q  <= k_q + 1'b1;
            st_q <= stage2_q ? S_RD : S_PM;
          end
        end
        S_B: begin
          // One butterfly stage of the Hadamard mix per cycle.
          for (int i = 0; i < NUM_PAIRS; i++) begin
            if ((i & (1 << b_q)) == 0) begin
              mix_q[i]              <= add_s(mix_q[i], mix_q[i + (1 << b_q)]);
              mix_q[i + (1 << b_q)] <= sub_s(mix_q[i], mix_q[i + (1 << b_q)]);
            end
          end
          b_q <= b_q + 1'b1;
          if (b_q == 2'd2) st_q <= S_O1;
        end
        S_O1: st_q <= S_O2;
        S_O2: begin
          w_q  <= qm21;
          st_q <= S_O3;
        end
        S_O3: begin
          xo_q <= sub_s(mix_q[1], qm21);
          st_q <= S_O4;
        end
        S_O4: begin
          rw_q <= qm28;
          st_q <= S_O5;
        end
        S_O5: begin
          rx_q <= qm28;
          st_q <= S_O6;
        end
        S_O6: begin
          ry_q <= qm28;
          st_q <= S_O7;
        end
        S_O7: begin
          rz_q <= qm28;
          st_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            w_out_q     <= rw_q;
            x_out_q     <= rx_q;
            y_out_q     <= ry_q;
            z_out_q     <= rz_q;
            out_valid_q <= 1'b1;
            k_q         <= '0;
            stage2_q    <= 1'b1;
            st_q        <= S_RD;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = st_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign w_out_o     = w_out_q;
  assign x_out_o     = x_out_q;
  assign y_out_o     = y_out_q;
  assign z_out_o     = z_out_q;

endmodule
